// ===== rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// Used by the front end, the back end and the top level; depends on nothing.
package deq_pkg;

  // Field widths of the stream items.
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // Stream bus widths, padded to whole bytes.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // Default ring depth.
  localparam int DEPTH_DEFAULT = 32;

  // Command codes as they arrive on the input stream.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP_FWD   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP_REV   = 3'd5;

  // Status codes returned with each result.
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_WAS_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOW_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd3;

  // Operation kinds after decode.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DUMP_FWD,
    OP_DUMP_REV
  } op_kind_t;

  // One decoded request passed from the front end to the back end.
  typedef struct packed {
    op_kind_t                   kind;
    logic signed [VALUE_W-1:0]  value;
  } op_t;

endpackage

// ===== rtl/deq_front.sv =====
// Front end of the double-ended queue: accepts requests, decodes them and
// holds them in a two-entry queue for the back end. Depends on deq_pkg.
module deq_front import deq_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [CMD_W-1:0]           command,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       op_valid,
  input  logic                       op_ready,
  output op_t                        op
);

  localparam int QD = 2;

  op_t          fifo [QD];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;
  logic         known;
  op_kind_t     kind;
  logic         push;
  logic         pop;

  // Decode the command; unused codes are accepted and dropped.
  always_comb begin
    known = 1'b1;
    kind  = OP_PUSH_FRONT;
    unique case (command)
      CMD_PUSH_FRONT: kind = OP_PUSH_FRONT;
      CMD_PUSH_BACK:  kind = OP_PUSH_BACK;
      CMD_POP_FRONT:  kind = OP_POP_FRONT;
      CMD_POP_BACK:   kind = OP_POP_BACK;
      CMD_DUMP_FWD:   kind = OP_DUMP_FWD;
      CMD_DUMP_REV:   kind = OP_DUMP_REV;
      default:        known = 1'b0;
    endcase
  end

  // Queue handshakes.
  assign in_ready = (fill != 2'(QD));
  assign push     = in_valid && in_ready && known;
  assign op_valid = (fill != 2'd0);
  assign pop      = op_valid && op_ready;
  assign op       = fifo[rd_ptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr].kind  <= kind;
      fifo[wr_ptr].value <= value;
    end
  end

endmodule

// ===== rtl/deq_back.sv =====
// Back end of the double-ended queue: owns the ring memory, its front index
// and fill count, and produces the result stream. Depends on deq_pkg.
module deq_back import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        op_valid,
  output logic                        op_ready,
  input  op_t                         op,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [STATUS_W-1:0]         status,
  output logic signed [VALUE_W-1:0]   value_res,
  output logic [COUNT_W-1:0]          count,
  output logic                        last
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DUMP_RD,
    ST_DUMP_OUT
  } state_t;

  state_t                      state;
  logic [IW-1:0]               front_index;
  logic [CW-1:0]               fill_count;
  logic [IW-1:0]               dump_idx;
  logic                        dump_rev;

  logic signed [VALUE_W-1:0]   mem [DEPTH];
  logic signed [VALUE_W-1:0]   rd_data;

  logic                        out_free;
  logic                        fire;
  logic                        is_full;
  logic                        is_empty;
  logic                        is_dump;
  logic                        res_load;
  logic                        dump_last;
  logic [SW-1:0]               back_sum;
  logic [SW-1:0]               dump_sum;
  logic [CW-1:0]               dump_off;
  logic [IW-1:0]               back_pos;
  logic [IW-1:0]               dump_pos;
  logic [IW-1:0]               front_dec;
  logic [IW-1:0]               front_inc;
  logic                        wr_en;
  logic [IW-1:0]               wr_addr;

  // The output register can take a new result when empty or being drained.
  assign out_free = !res_valid || res_ready;
  assign op_ready = (state == ST_IDLE) && out_free;
  assign fire     = op_valid && op_ready;
  assign is_full  = (fill_count == CW'(DEPTH));
  assign is_empty = (fill_count == '0);

  // A result is loaded for every push, pop and empty dump, and per dumped entry.
  assign is_dump  = (op.kind == OP_DUMP_FWD) || (op.kind == OP_DUMP_REV);
  assign res_load = (fire && !(is_dump && !is_empty)) ||
                    ((state == ST_DUMP_OUT) && out_free);

  // Ring positions: one past the back, one before and after the front.
  assign back_sum  = SW'(front_index) + SW'(fill_count);
  assign back_pos  = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);
  assign front_dec = (front_index == '0) ? IW'(DEPTH - 1) : front_index - IW'(1);
  assign front_inc = (front_index == IW'(DEPTH - 1)) ? '0 : front_index + IW'(1);

  // Position of the entry being dumped, counted from the front or the back.
  assign dump_off  = dump_rev ? (fill_count - CW'(1) - CW'(dump_idx)) : CW'(dump_idx);
  assign dump_sum  = SW'(front_index) + SW'(dump_off);
  assign dump_pos  = (dump_sum >= SW'(DEPTH)) ? IW'(dump_sum - SW'(DEPTH)) : IW'(dump_sum);
  assign dump_last = ((CW'(dump_idx) + CW'(1)) == fill_count);

  // Ring write for an accepted push.
  assign wr_en   = fire && !is_full &&
                   (op.kind == OP_PUSH_FRONT || op.kind == OP_PUSH_BACK);
  assign wr_addr = (op.kind == OP_PUSH_FRONT) ? front_dec : back_pos;

  // Ring memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= op.value;
    if (state == ST_DUMP_RD) rd_data <= mem[dump_pos];
  end

  // Sequencer, queue bookkeeping and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      front_index <= '0;
      fill_count  <= '0;
      res_valid   <= 1'b0;
      dump_idx    <= '0;
      dump_rev    <= 1'b0;
    end else begin
      if (res_load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (fire) begin
            value_res <= '0;
            last      <= 1'b1;
            case (op.kind) inside
              OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (is_full) begin
                  status <= STATUS_FULL;
                  count  <= COUNT_W'(fill_count);
                end else begin
                  status     <= STATUS_OK;
                  count      <= COUNT_W'(fill_count + CW'(1));
                  fill_count <= fill_count + CW'(1);
                  if (op.kind == OP_PUSH_FRONT) front_index <= front_dec;
                end
              end
              OP_POP_FRONT, OP_POP_BACK: begin
                if (is_empty) begin
                  status <= STATUS_WAS_EMPTY;
                  count  <= '0;
                end else begin
                  status     <= (fill_count == CW'(1)) ? STATUS_NOW_EMPTY : STATUS_OK;
                  count      <= COUNT_W'(fill_count - CW'(1));
                  fill_count <= fill_count - CW'(1);
                  if (op.kind == OP_POP_FRONT) front_index <= front_inc;
                end
              end
              default: begin
                // Dump in either direction.
                if (is_empty) begin
                  status    <= STATUS_WAS_EMPTY;
                  count     <= '0;
                end else begin
                  dump_idx <= '0;
                  dump_rev <= (op.kind == OP_DUMP_REV);
                  state    <= ST_DUMP_RD;
                end
              end
            endcase
          end
        end
        ST_DUMP_RD: begin
          state <= ST_DUMP_OUT;
        end
        ST_DUMP_OUT: begin
          if (out_free) begin
            status    <= STATUS_OK;
            value_res <= rd_data;
            count     <= COUNT_W'(fill_count);
            last      <= dump_last;
            if (dump_last) begin
              state <= ST_IDLE;
            end else begin
              dump_idx <= dump_idx + IW'(1);
              state    <= ST_DUMP_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/double_ended_queue_top.sv =====
// Top level of the double-ended queue: stream ports and packing.
// Instantiates deq_front and deq_back; depends on deq_pkg.
//
// Usage: each request on the slave stream carries a command (push front or
// back, pop front or back, dump forward or reverse) and a value used by
// pushes. Push and pop each return one result on the master stream with a
// status, the entry count after the command, and tlast set. A dump returns
// one result per held entry in the chosen order, tlast on the final one, or
// a single "was empty" result when the queue holds nothing. Codes 6 and 7
// are taken and produce no result.
// Timing: a result passes through the request queue and the result register
// when the back end is free. Push and pop run at one per cycle while the
// receiver takes results; a dump reads each entry through the registered read
// of the ring memory and holds off further requests until it finishes. A
// two-entry request queue lets the input keep flowing while the back end or
// the receiver stalls; a stalled receiver holds the result register and the
// back end waits behind it. Reset empties the queue; there is no clearing pass.
module double_ended_queue_top import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // command[2:0], value[34:3], zero pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // value_res[31:0], count[37:32], zero pad
  output logic [STATUS_W-1:0]    m_axis_tuser,   // status[1:0]
  output logic                   m_axis_tlast
);

  logic                        op_valid;
  logic                        op_ready;
  op_t                         op;
  logic [CMD_W-1:0]            command;
  logic signed [VALUE_W-1:0]   value;
  logic signed [VALUE_W-1:0]   value_res;
  logic [COUNT_W-1:0]          count;

  // Unpack the request fields.
  assign command = s_axis_tdata[CMD_W-1:0];
  assign value   = s_axis_tdata[CMD_W+VALUE_W-1:CMD_W];

  deq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .command  (command),
    .value    (value),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .status    (m_axis_tuser),
    .value_res (value_res),
    .count     (count),
    .last      (m_axis_tlast)
  );

  // Pack the result fields.
  assign m_axis_tdata = {{(OUT_DATA_W - VALUE_W - COUNT_W){1'b0}}, count, value_res};

endmodule
